// File: src/ring_buffer_deque_core_assert.svh
// ----------------------------------------------------------------------------
// Ring buffer deque assertion macros
// Shorthand for the clocked checks at the end of the deque core.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define RBDQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define RBDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rbdq_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer deque package
// Sizes, operation codes and index helpers shared by the deque core.
// ----------------------------------------------------------------------------
package rbdq_pkg;

    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CAP_W     = 9;
    localparam int MODE_W    = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_BITS   = 32 + 1 + 1 + 1 + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND     = 3'd0,
        MODE_PREPEND    = 3'd1,
        MODE_POP_HEAD   = 3'd2,
        MODE_POP_TAIL   = 3'd3,
        MODE_ITER_START = 3'd4,
        MODE_ITER_NEXT  = 3'd5,
        MODE_CLEAR      = 3'd6
    } t_mode;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // Register value to the ring size in use: zero acts as one, clamp at DEPTH.
    function automatic t_cnt eff_cap(input logic [CAP_W-1:0] cfg);
        if (cfg == '0) begin
            return t_cnt'(1);
        end else if (int'(cfg) > DEPTH) begin
            return t_cnt'(DEPTH);
        end
        return t_cnt'(cfg);
    endfunction

    function automatic t_idx inc_idx(input t_idx i, input t_cnt cap);
        t_cnt nxt;
        nxt = {1'b0, i} + 1'b1;
        return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
    endfunction

    function automatic t_idx dec_idx(input t_idx i, input t_cnt cap);
        t_cnt last;
        last = cap - 1'b1;
        if (i == '0 || {1'b0, i} > cap) begin
            return last[IDX_W-1:0];
        end
        return i - 1'b1;
    endfunction

endpackage

// File: src/ring_buffer_deque_core.sv
// ----------------------------------------------------------------------------
// Ring buffer deque core
// Double-ended queue of 32-bit words in a ring RAM with head, tail and count.
// ----------------------------------------------------------------------------
// The deque takes one operation per clock and returns one result for each,
// registered through the operation stage and the output register; the only
// stall comes from output backpressure. Each operation does at most one RAM
// access (a write for a push, a read for a pop or iterator step), and pointers
// and count update at the input transfer, so back-to-back operations see each
// other's effect. Capacity may only be written while the deque is idle. The
// RAM is not cleared after reset: entries are defined once pushed.
`include "ring_buffer_deque_core_assert.svh"

module ring_buffer_deque_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbdq_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rbdq_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // value[31:0]
    input  logic [rbdq_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[2:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // data_out[31:0], ok[32], is_empty[33], is_full[34], count[43:35], zero pad
    output logic [rbdq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int PAD_W = rbdq_pkg::OUT_DATA_W - rbdq_pkg::OUT_BITS;

    logic [rbdq_pkg::CAP_W-1:0] r_cap_cfg;
    rbdq_pkg::t_idx r_head, n_head;
    rbdq_pkg::t_idx r_tail, n_tail;
    rbdq_pkg::t_cnt r_count, n_count;
    rbdq_pkg::t_idx r_iter_idx, n_iter_idx;
    rbdq_pkg::t_cnt r_iter_rem, n_iter_rem;

    rbdq_pkg::t_cnt cap;
    rbdq_pkg::t_mode mode;
    logic s_fire, pend_adv, full_now;
    logic mem_we, mem_re;
    rbdq_pkg::t_idx mem_waddr, mem_raddr;
    logic [rbdq_pkg::WORD_BITS-1:0] mem_rdata;
    logic op_ok, op_rd;

    // Operation stage: waits on the RAM read.
    logic r_pend, r_p_rd, r_p_ok, r_p_empty, r_p_full;
    rbdq_pkg::t_cnt r_p_count;

    // Output register.
    logic r_out_valid, r_out_ok, r_out_empty, r_out_full;
    logic [31:0] r_out_data;
    rbdq_pkg::t_cnt r_out_count;

    assign cap      = rbdq_pkg::eff_cap(r_cap_cfg);
    assign mode     = rbdq_pkg::t_mode'(s_axis_tuser);
    assign full_now = (r_count >= cap);
    assign pend_adv = r_pend && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_pend || pend_adv;
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_iter_idx = r_iter_idx;
        n_iter_rem = r_iter_rem;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_tail;
        mem_raddr  = r_head;
        op_ok      = 1'b0;
        op_rd      = 1'b0;
        unique case (mode)
            rbdq_pkg::MODE_APPEND: begin
                if (!full_now) begin
                    mem_we  = 1'b1;
                    mem_waddr = r_tail;
                    n_tail  = rbdq_pkg::inc_idx(r_tail, cap);
                    n_count = r_count + 1'b1;
                    op_ok   = 1'b1;
                end
            end
            rbdq_pkg::MODE_PREPEND: begin
                if (!full_now) begin
                    n_head  = rbdq_pkg::dec_idx(r_head, cap);
                    mem_we  = 1'b1;
                    mem_waddr = n_head;
                    n_count = r_count + 1'b1;
                    op_ok   = 1'b1;
                end
            end
            rbdq_pkg::MODE_POP_HEAD: begin
                if (r_count != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head;
                    n_head    = rbdq_pkg::inc_idx(r_head, cap);
                    n_count   = r_count - 1'b1;
                    op_ok     = 1'b1;
                    op_rd     = 1'b1;
                end
            end
            rbdq_pkg::MODE_POP_TAIL: begin
                if (r_count != '0) begin
                    n_tail    = rbdq_pkg::dec_idx(r_tail, cap);
                    mem_re    = 1'b1;
                    mem_raddr = n_tail;
                    n_count   = r_count - 1'b1;
                    op_ok     = 1'b1;
                    op_rd     = 1'b1;
                end
            end
            rbdq_pkg::MODE_ITER_START: begin
                n_iter_idx = r_head;
                n_iter_rem = r_count;
                op_ok      = 1'b1;
            end
            rbdq_pkg::MODE_ITER_NEXT: begin
                if (r_iter_rem != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = r_iter_idx;
                    n_iter_idx = rbdq_pkg::inc_idx(r_iter_idx, cap);
                    n_iter_rem = r_iter_rem - 1'b1;
                    op_ok      = 1'b1;
                    op_rd      = 1'b1;
                end
            end
            rbdq_pkg::MODE_CLEAR: begin
                n_head     = '0;
                n_tail     = '0;
                n_count    = '0;
                n_iter_idx = '0;
                n_iter_rem = '0;
                op_ok      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    rbdq_ram #(
        .WIDTH (rbdq_pkg::WORD_BITS),
        .DEPTH (rbdq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_fire && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (s_axis_tdata[rbdq_pkg::WORD_BITS-1:0]),
        .i_re    (s_fire && mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg  <= rbdq_pkg::CAP_W'(256);
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_iter_idx <= '0;
            r_iter_rem <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_wdata;
            end
            if (s_fire) begin
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_count    <= n_count;
                r_iter_idx <= n_iter_idx;
                r_iter_rem <= n_iter_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_pend <= 1'b1;
            end else if (pend_adv) begin
                r_pend <= 1'b0;
            end
            if (pend_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_p_rd    <= op_rd;
            r_p_ok    <= op_ok;
            r_p_count <= n_count;
            r_p_empty <= (n_count == '0);
            r_p_full  <= (n_count >= cap);
        end
        if (pend_adv) begin
            // Zero-extend narrower stored words to the 32-bit result.
            r_out_data  <= r_p_rd ? 32'(mem_rdata) : '0;
            r_out_ok    <= r_p_ok;
            r_out_empty <= r_p_empty;
            r_out_full  <= r_p_full;
            r_out_count <= r_p_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_full, r_out_empty,
                            r_out_ok, r_out_data};

    `RBDQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        (r_count <= rbdq_pkg::t_cnt'(rbdq_pkg::DEPTH)), "entry count above ring depth")
    `RBDQ_ASSERT_NEXT(a_pend_holds, i_clk, i_rst_n,
        (r_pend && r_out_valid && !m_axis_tready), (r_pend), "pending result dropped")
    `RBDQ_ASSERT_NEXT(a_append_count, i_clk, i_rst_n,
        (s_fire && mode == rbdq_pkg::MODE_APPEND && !full_now),
        (r_count == rbdq_pkg::t_cnt'($past(r_count) + 1'b1)), "append did not grow count")
    `RBDQ_ASSERT_NEXT(a_full_no_write, i_clk, i_rst_n,
        (s_fire && full_now && (mode == rbdq_pkg::MODE_APPEND ||
         mode == rbdq_pkg::MODE_PREPEND)),
        (r_count == $past(r_count)), "push into full deque changed count")

endmodule

// File: src/rbdq_ram.sv
// ----------------------------------------------------------------------------
// Ring buffer deque RAM
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module rbdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
